### src/wildcard_rule_priority_match_top_defines.svh
// ----------------------------------------------------------------------------
// Rule match defines
// Assertion macros shared by the checker of the rule match block.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_RULE_PRIORITY_MATCH_TOP_DEFINES_SVH
`define WILDCARD_RULE_PRIORITY_MATCH_TOP_DEFINES_SVH

// same-cycle implication
`define WRPM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rule match check failed");

// next-cycle implication
`define WRPM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rule match check failed");

`endif

### src/wrpm_pkg.sv
// ----------------------------------------------------------------------------
// Rule match package
// Sizes, command codes and the types passed along the row of rule cells.
// ----------------------------------------------------------------------------
package wrpm_pkg;

   localparam int RULES       = 16;
   localparam int POSITIONS   = 5;
   localparam int SYMBOL_BITS = 4;

   localparam int SYM_W    = POSITIONS * SYMBOL_BITS;
   localparam int IDX_W    = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int COUNT_W  = $clog2(RULES + 1);
   localparam int NPOS_W   = $clog2(POSITIONS + 1);
   localparam int SLOT_W   = 4;
   localparam int RIDX_W   = 4;
   localparam int SEL_W    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int MULT_W   = 32;
   localparam int RCOUNT_W = 5;
   localparam int REELS_W  = 3;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [RCOUNT_W-1:0] RULE_COUNT_RESET = RCOUNT_W'(0);
   localparam logic [REELS_W-1:0]  REELS_RESET      = REELS_W'(5);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_MATCH = 1'b1;

   localparam logic REG_RULE_COUNT = 1'b0;
   localparam logic REG_REELS      = 1'b1;

   typedef struct packed {
      logic [COUNT_W-1:0] n;
      logic [NPOS_W-1:0]  npos;
   } wrpm_cfg_type;

   typedef struct packed {
      logic                 we;
      logic [SLOT_W-1:0]    slot;
      logic [SYM_W-1:0]     symbols;
      logic [POSITIONS-1:0] care;
      logic [MULT_W-1:0]    multiplier;
      logic                 jackpot;
   } wrpm_load_type;

   typedef struct packed {
      logic              valid;
      logic              found;
      logic [SYM_W-1:0]  symbols;
      logic [RIDX_W-1:0] rule_index;
      logic [MULT_W-1:0] multiplier;
      logic              jackpot;
   } wrpm_token_type;

endpackage

### src/wrpm_cell.sv
// ----------------------------------------------------------------------------
// Rule cell
// Holds one rule slot and compares the passing query against it.
// ----------------------------------------------------------------------------
module wrpm_cell
   import wrpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     cell_index,
   input  wrpm_cfg_type         cfg,
   input  wrpm_load_type        load,
   input  wrpm_token_type       tok_in,
   output wrpm_token_type       tok_out
);

   logic [SYM_W-1:0]     symbols_ff;
   logic [POSITIONS-1:0] care_ff;
   logic [MULT_W-1:0]    mult_ff;
   logic                 jackpot_ff;
   wrpm_token_type       tok_ff;
   wrpm_token_type       tok_in_next;

   logic [SEL_W-1:0]     idx_ext;
   logic                 sel;
   logic                 fits;
   logic                 hit;

   assign idx_ext = SEL_W'(cell_index);
   assign sel     = load.we && (SEL_W'(load.slot) == idx_ext);

   always_ff @(posedge clock) begin
      if (sel) begin
         symbols_ff <= load.symbols;
         care_ff    <= load.care;
         mult_ff    <= load.multiplier;
         jackpot_ff <= load.jackpot;
      end
   end

   always_comb begin
      fits = 1'b1;
      for (int i = 0; i < POSITIONS; i++) begin
         if ((i < int'(cfg.npos)) && care_ff[i] &&
             (tok_in.symbols[i*SYMBOL_BITS +: SYMBOL_BITS] !=
              symbols_ff[i*SYMBOL_BITS +: SYMBOL_BITS])) begin
            fits = 1'b0;
         end
      end
   end

   assign hit = tok_in.valid && !tok_in.found && (COUNT_W'(cell_index) < cfg.n) && fits;

   always_comb begin
      tok_in_next = tok_in;
      if (hit) begin
         tok_in_next.found      = 1'b1;
         tok_in_next.rule_index = idx_ext[RIDX_W-1:0];
         tok_in_next.multiplier = mult_ff;
         tok_in_next.jackpot    = jackpot_ff;
      end
   end

   // advance the query one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

### src/wildcard_rule_priority_match_top.sv
// ----------------------------------------------------------------------------
// Wildcard rule priority match
// Priority ternary rule table built as a row of rule cells.
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-------------------------------
//  request   | start, busy                   | req_cmd .. req_jackpot
//  response  | rsp_valid (one-cycle strobe)  | rsp_matched .. rsp_jackpot_hit
//  config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  A load transfer leaves busy low.
//  A match transfer walks the query through the RULES cells, one per cycle;
//  the response strobe comes from the register of the last cell, and busy
//  is high until the end of that cycle, so a new request is taken only
//  after the response.
//  Reset restores the registers; rule slots hold nothing until loaded.
//  The receiver cannot stall; each response is shown for one cycle only.
// ----------------------------------------------------------------------------
module wildcard_rule_priority_match_top
   import wrpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_cmd,
   input  logic [SLOT_W-1:0]    req_slot,
   input  logic [SYM_W-1:0]     req_symbols,
   input  logic [POSITIONS-1:0] req_care_mask,
   input  logic [MULT_W-1:0]    req_multiplier,
   input  logic                 req_jackpot,
   output logic                 rsp_valid,
   output logic                 rsp_matched,
   output logic [RIDX_W-1:0]    rsp_rule_index,
   output logic [MULT_W-1:0]    rsp_payout_multiplier,
   output logic                 rsp_jackpot_hit,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]    pwdata,
   output logic [DATA_W-1:0]    prdata,
   output logic                 pready
);

   logic [RCOUNT_W-1:0] rule_count_ff, rule_count_in;
   logic [REELS_W-1:0]  reels_ff, reels_in;
   logic                busy_ff, busy_in;
   logic                csr_write;
   logic                accept;
   wrpm_cfg_type        cfg;
   wrpm_load_type       load;
   wrpm_token_type      chain [RULES+1];

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign accept    = start && !busy_ff;

   always_comb begin
      rule_count_in = rule_count_ff;
      reels_in      = reels_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_RULE_COUNT: rule_count_in = pwdata[RCOUNT_W-1:0];
            REG_REELS:      reels_in      = pwdata[REELS_W-1:0];
            default:        rule_count_in = rule_count_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_RULE_COUNT: prdata = DATA_W'(rule_count_ff);
         REG_REELS:      prdata = DATA_W'(reels_ff);
         default:        prdata = '0;
      endcase
   end

   always_comb begin
      if (int'(rule_count_ff) > RULES) begin
         cfg.n = COUNT_W'(RULES);
      end else begin
         cfg.n = COUNT_W'(rule_count_ff);
      end
      if (int'(reels_ff) > POSITIONS) begin
         cfg.npos = NPOS_W'(POSITIONS);
      end else begin
         cfg.npos = NPOS_W'(reels_ff);
      end
   end

   assign load.we         = accept && (req_cmd == CMD_LOAD);
   assign load.slot       = req_slot;
   assign load.symbols    = req_symbols;
   assign load.care       = req_care_mask;
   assign load.multiplier = req_multiplier;
   assign load.jackpot    = req_jackpot;

   assign chain[0].valid      = accept && (req_cmd == CMD_MATCH);
   assign chain[0].found      = 1'b0;
   assign chain[0].symbols    = req_symbols;
   assign chain[0].rule_index = '0;
   assign chain[0].multiplier = '0;
   assign chain[0].jackpot    = 1'b0;

   for (genvar g = 0; g < RULES; g++) begin : g_cell
      wrpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(g)),
         .cfg        (cfg),
         .load       (load),
         .tok_in     (chain[g]),
         .tok_out    (chain[g+1])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (chain[0].valid) begin
         busy_in = 1'b1;
      end else if (chain[RULES].valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= RULE_COUNT_RESET;
         reels_ff      <= REELS_RESET;
         busy_ff       <= 1'b0;
      end else begin
         rule_count_ff <= rule_count_in;
         reels_ff      <= reels_in;
         busy_ff       <= busy_in;
      end
   end

   assign busy                  = busy_ff;
   assign rsp_valid             = chain[RULES].valid;
   assign rsp_matched           = chain[RULES].found;
   assign rsp_rule_index        = chain[RULES].rule_index;
   assign rsp_payout_multiplier = chain[RULES].multiplier;
   assign rsp_jackpot_hit       = chain[RULES].jackpot;

endmodule

### src/wrpm_checker.sv
// ----------------------------------------------------------------------------
// Rule match checker
// Port-level checks on request, response and busy timing.
// ----------------------------------------------------------------------------
`include "wildcard_rule_priority_match_top_defines.svh"

module wrpm_checker
   import wrpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 req_cmd,
   input  logic                 rsp_valid,
   input  logic                 rsp_matched,
   input  logic [RIDX_W-1:0]    rsp_rule_index,
   input  logic [MULT_W-1:0]    rsp_payout_multiplier,
   input  logic                 rsp_jackpot_hit
);

   logic miss_clean;

   assign miss_clean = (rsp_rule_index == '0) && (rsp_payout_multiplier == '0) &&
                       !rsp_jackpot_hit;

   `WRPM_ASSERT_NOW(a_rsp_while_busy, rsp_valid, busy)
   `WRPM_ASSERT_NOW(a_miss_is_zero, rsp_valid && !rsp_matched, miss_clean)
   `WRPM_ASSERT_NEXT(a_match_sets_busy, start && !busy && (req_cmd == CMD_MATCH), busy)
   `WRPM_ASSERT_NEXT(a_load_stays_idle, start && !busy && (req_cmd == CMD_LOAD), !busy)
   `WRPM_ASSERT_NOW(a_busy_ends_on_rsp, $fell(busy) && !$past(reset), $past(rsp_valid))

endmodule

bind wildcard_rule_priority_match_top wrpm_checker u_wrpm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .req_cmd               (req_cmd),
   .rsp_valid             (rsp_valid),
   .rsp_matched           (rsp_matched),
   .rsp_rule_index        (rsp_rule_index),
   .rsp_payout_multiplier (rsp_payout_multiplier),
   .rsp_jackpot_hit       (rsp_jackpot_hit)
);

### bench/wildcard_rule_priority_match_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rule match checker
// Watches the request, response and register ports of the rule match block.
// Keeps its own copy of the rule table and registers, works out the outcome
// of every accepted match request and compares each response strobe with
// the oldest outcome still awaited. Counts failures for the bench top.
// ----------------------------------------------------------------------------
module wildcard_rule_priority_match_checker
   import wrpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 req_cmd,
   input  logic [SLOT_W-1:0]    req_slot,
   input  logic [SYM_W-1:0]     req_symbols,
   input  logic [POSITIONS-1:0] req_care_mask,
   input  logic [MULT_W-1:0]    req_multiplier,
   input  logic                 req_jackpot,
   input  logic                 rsp_valid,
   input  logic                 rsp_matched,
   input  logic [RIDX_W-1:0]    rsp_rule_index,
   input  logic [MULT_W-1:0]    rsp_payout_multiplier,
   input  logic                 rsp_jackpot_hit,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]    pwdata,
   input  logic                 pready,
   output int                   fail_count,
   output int                   outstanding
);

   typedef struct packed {
      logic              matched;
      logic [RIDX_W-1:0] rule_index;
      logic [MULT_W-1:0] payout;
      logic              jackpot;
   } match_outcome_type;

   logic [SYM_W-1:0]     tbl_symbols [RULES];
   logic [POSITIONS-1:0] tbl_care    [RULES];
   logic [MULT_W-1:0]    tbl_mult    [RULES];
   logic                 tbl_jackpot [RULES];
   logic [RCOUNT_W-1:0]  rule_count;
   logic [REELS_W-1:0]   reels;
   match_outcome_type    awaited [$];
   int                   fails = 0;

   assign fail_count = fails;

   function automatic match_outcome_type scan_rules(logic [SYM_W-1:0] syms);
      match_outcome_type res;
      int                n;
      int                npos;
      bit                hit;
      res  = '0;
      n    = (rule_count > RULES) ? RULES : int'(rule_count);
      npos = (reels > POSITIONS) ? POSITIONS : int'(reels);
      for (int r = 0; r < n; r++) begin
         hit = 1'b1;
         for (int p = 0; p < npos; p++) begin
            if (tbl_care[r][p] && syms[p*SYMBOL_BITS +: SYMBOL_BITS]
                  != tbl_symbols[r][p*SYMBOL_BITS +: SYMBOL_BITS])
               hit = 1'b0;
         end
         if (hit) begin
            res.matched    = 1'b1;
            res.rule_index = RIDX_W'(r);
            res.payout     = tbl_mult[r];
            res.jackpot    = tbl_jackpot[r];
            return res;
         end
      end
      return res;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fails++;
      end
   endtask

   // sample mid-cycle: inputs move only at the rising edge
   always @(negedge clock) begin
      match_outcome_type want;
      if (reset) begin
         rule_count = RULE_COUNT_RESET;
         reels      = REELS_RESET;
         awaited.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[ADDR_W-1:2] == REG_RULE_COUNT)
               rule_count = pwdata[RCOUNT_W-1:0];
            else if (paddr[ADDR_W-1:2] == REG_REELS)
               reels = pwdata[REELS_W-1:0];
         end
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0h %0h %0h %0h",
                        $time, rsp_matched, rsp_rule_index, rsp_payout_multiplier,
                        rsp_jackpot_hit);
               fails++;
            end else begin
               want = awaited.pop_front();
               compare_field("matched", want.matched, rsp_matched);
               compare_field("rule_index", want.rule_index, rsp_rule_index);
               compare_field("payout_multiplier", want.payout, rsp_payout_multiplier);
               compare_field("jackpot_hit", want.jackpot, rsp_jackpot_hit);
            end
         end
         if (start && !busy) begin
            if (req_cmd == CMD_LOAD) begin
               tbl_symbols[req_slot] = req_symbols;
               tbl_care[req_slot]    = req_care_mask;
               tbl_mult[req_slot]    = req_multiplier;
               tbl_jackpot[req_slot] = req_jackpot;
            end else begin
               awaited = {awaited, scan_rules(req_symbols)};
            end
         end
      end
      outstanding <= awaited.size();
   end

endmodule

### bench/wildcard_rule_priority_match_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rule match bench
// Drives load and match requests and register writes into the rule match
// block: a short directed run over the corner cases, then random phases
// under a range of rule counts and reel counts, with random request gaps.
// The checker beside the block judges every response; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module wildcard_rule_priority_match_top_test;
   import wrpm_pkg::*;

   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 185;
   localparam int SETTLE      = 20;
   localparam int QUIET_LIMIT = 400;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic                 cmd;
      logic [SLOT_W-1:0]    slot;
      logic [SYM_W-1:0]     symbols;
      logic [POSITIONS-1:0] care;
      logic [MULT_W-1:0]    multiplier;
      logic                 jackpot;
   } rule_req_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_cmd = CMD_LOAD;
   logic [SLOT_W-1:0]    req_slot = '0;
   logic [SYM_W-1:0]     req_symbols = '0;
   logic [POSITIONS-1:0] req_care_mask = '0;
   logic [MULT_W-1:0]    req_multiplier = '0;
   logic                 req_jackpot = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_matched;
   logic [RIDX_W-1:0]    rsp_rule_index;
   logic [MULT_W-1:0]    rsp_payout_multiplier;
   logic                 rsp_jackpot_hit;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_W-1:0]    paddr = '0;
   logic [DATA_W-1:0]    pwdata = '0;
   logic [DATA_W-1:0]    prdata;
   logic                 pready;
   int                   fail_count;
   int                   outstanding;
   int                   cycles = 0;
   logic [SYM_W-1:0]     loaded_syms [RULES];

   wildcard_rule_priority_match_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_cmd               (req_cmd),
      .req_slot              (req_slot),
      .req_symbols           (req_symbols),
      .req_care_mask         (req_care_mask),
      .req_multiplier        (req_multiplier),
      .req_jackpot           (req_jackpot),
      .rsp_valid             (rsp_valid),
      .rsp_matched           (rsp_matched),
      .rsp_rule_index        (rsp_rule_index),
      .rsp_payout_multiplier (rsp_payout_multiplier),
      .rsp_jackpot_hit       (rsp_jackpot_hit),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   wildcard_rule_priority_match_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_cmd               (req_cmd),
      .req_slot              (req_slot),
      .req_symbols           (req_symbols),
      .req_care_mask         (req_care_mask),
      .req_multiplier        (req_multiplier),
      .req_jackpot           (req_jackpot),
      .rsp_valid             (rsp_valid),
      .rsp_matched           (rsp_matched),
      .rsp_rule_index        (rsp_rule_index),
      .rsp_payout_multiplier (rsp_payout_multiplier),
      .rsp_jackpot_hit       (rsp_jackpot_hit),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .pready                (pready),
      .fail_count            (fail_count),
      .outstanding           (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [SYM_W-1:0] few_symbols();
      logic [SYM_W-1:0] syms;
      syms = '0;
      for (int p = 0; p < POSITIONS; p++)
         syms[p*SYMBOL_BITS +: SYMBOL_BITS] = SYMBOL_BITS'($urandom_range(0, 2));
      return syms;
   endfunction

   function automatic rule_req_type make_load(int slot, logic [SYM_W-1:0] syms,
                                              logic [POSITIONS-1:0] care,
                                              logic [MULT_W-1:0] mult, logic jp);
      rule_req_type it;
      it.cmd        = CMD_LOAD;
      it.slot       = SLOT_W'(slot);
      it.symbols    = syms;
      it.care       = care;
      it.multiplier = mult;
      it.jackpot    = jp;
      return it;
   endfunction

   function automatic rule_req_type make_match(logic [SYM_W-1:0] syms);
      rule_req_type it;
      it.cmd        = CMD_MATCH;
      it.slot       = SLOT_W'($urandom());
      it.symbols    = syms;
      it.care       = POSITIONS'($urandom());
      it.multiplier = $urandom();
      it.jackpot    = 1'($urandom());
      return it;
   endfunction

   function automatic rule_req_type random_load(int slot);
      logic [SYM_W-1:0] syms;
      syms = ($urandom_range(0, 1) == 0) ? few_symbols() : SYM_W'($urandom());
      return make_load(slot, syms, POSITIONS'($urandom()), $urandom(), 1'($urandom()));
   endfunction

   function automatic rule_req_type random_item();
      logic [SYM_W-1:0] syms;
      int               pick;
      int               p;
      pick = $urandom_range(0, 99);
      if (pick < 25)
         return random_load($urandom_range(0, RULES - 1));
      if (pick < 70) begin
         // aim at a stored rule, sometimes one position off
         syms = loaded_syms[$urandom_range(0, RULES - 1)];
         if ($urandom_range(0, 1) == 0) begin
            p = $urandom_range(0, POSITIONS - 1);
            syms[p*SYMBOL_BITS +: SYMBOL_BITS] = SYMBOL_BITS'($urandom());
         end
      end else if (pick < 85) begin
         syms = few_symbols();
      end else begin
         syms = SYM_W'($urandom());
      end
      return make_match(syms);
   endfunction

   // entered and left at a rising edge; start stays high after the transfer
   task automatic send(rule_req_type it, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= it.cmd;
      req_slot       <= it.slot;
      req_symbols    <= it.symbols;
      req_care_mask  <= it.care;
      req_multiplier <= it.multiplier;
      req_jackpot    <= it.jackpot;
      if (it.cmd == CMD_LOAD)
         loaded_syms[it.slot] = it.symbols;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0 || busy);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper bits of the write data carry noise
   task automatic reconfigure(int count, int nreels);
      drain();
      write_reg(REG_RULE_COUNT, ($urandom() & ~32'h1F) | DATA_W'(count));
      write_reg(REG_REELS, ($urandom() & ~32'h7) | DATA_W'(nreels));
   endtask

   initial begin
      bit steady;
      int gap;
      int waited;
      foreach (loaded_syms[i]) loaded_syms[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no rules in use yet
      send(make_match('0), 0);
      send(make_match('1), 2);
      send(make_load(0, 20'h12345, 5'h1F, 32'hFFFF_FFFF, 1'b1), 0);
      send(make_load(1, 20'h0000F, 5'h01, 32'h0001_0000, 1'b0), 1);
      send(make_load(2, 20'hFFFFF, 5'h1F, 32'h0000_0000, 1'b0), 0);
      send(make_load(3, 20'hABCDE, 5'h00, 32'h8000_0000, 1'b1), 3);
      reconfigure(4, 5);
      send(make_match(20'h12345), 0);
      send(make_match(20'h5432F), 0);
      send(make_match(20'hFFFFF), 4);
      send(make_match(20'hFFFF0), 0);
      send(make_match(20'h12340), 6);
      // no reels compared: slot 0 wins
      reconfigure(4, 0);
      send(make_match(20'h77777), 0);
      reconfigure(4, 7);
      send(make_match(20'h12345), 0);
      reconfigure(3, 1);
      send(make_match(20'hFFFF5), 0);

      // fill every slot before wider rule counts
      for (int s = 0; s < RULES; s++)
         send(random_load(s), $urandom_range(0, 6));

      for (int ph = 0; ph < PHASES; ph++) begin
         unique case (ph)
            0:       reconfigure(16, 5);
            1:       reconfigure(31, 7);
            2:       reconfigure(17, 0);
            3:       reconfigure(1, 1);
            4:       reconfigure(0, 5);
            default: reconfigure($urandom_range(0, 31), $urandom_range(0, 7));
         endcase
         steady = (ph == 1) || ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 5 && k == PHASE_ITEMS / 2)
               drain();
            gap = steady ? 0 : $urandom_range(0, 6);
            send(random_item(), gap);
         end
      end

      start <= 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < QUIET_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
